// ===== rtl/mbrs_pkg.sv =====
// Shared constants, result type and sample encoder for the MIDI byte serializer.
`default_nettype none

package mbrs_pkg;

   localparam int QUEUE_SAMPLES_DEFAULT = 2048;
   localparam int SAMPLES_PER_BYTE      = 16;
   localparam int POS_W                 = 4;
   localparam int LEN_SAMPLES_W         = 12;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } op_type;

   typedef struct packed {
      logic sample_bit;
      logic queue_was_empty;
   } rsp_type;

   // Line sample at position pos of a byte: two start samples of 1, twelve data
   // samples where data sample j carries the inverse of bit (2j+1)/3, then two stop
   // samples of 0.
   function automatic logic sample_of(input logic [7:0] data, input logic [POS_W-1:0] pos);
      logic s;
      unique case (pos)
         4'd0, 4'd1: s = 1'b1;
         4'd2:       s = ~data[0];
         4'd3:       s = ~data[1];
         4'd4:       s = ~data[1];
         4'd5:       s = ~data[2];
         4'd6:       s = ~data[3];
         4'd7:       s = ~data[3];
         4'd8:       s = ~data[4];
         4'd9:       s = ~data[5];
         4'd10:      s = ~data[5];
         4'd11:      s = ~data[6];
         4'd12:      s = ~data[7];
         4'd13:      s = ~data[7];
         default:    s = 1'b0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrs_if.sv =====
// Request and response channel interfaces of the MIDI byte serializer.
`default_nettype none

interface mbrs_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;
   logic       first_of_message;
   logic [7:0] message_length;

   modport source (output valid, output opcode, output data_byte,
                   output first_of_message, output message_length, input ready);
   modport sink   (input valid, input opcode, input data_byte,
                   input first_of_message, input message_length, output ready);
endinterface

interface mbrs_rsp_if;
   logic valid;
   logic ready;
   logic sample_bit;
   logic queue_was_empty;

   modport source (output valid, output sample_bit, output queue_was_empty, input ready);
   modport sink   (input valid, input sample_bit, input queue_was_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbrs_byte_store.sv =====
// Byte queue memory with a registered read port and write-to-read bypass.
`default_nettype none

module mbrs_byte_store #(
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A byte written in the same cycle as its slot is read comes straight through.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/midi_byte_resampled_serializer.sv =====
// Top level of the MIDI byte serializer for a 48 kHz one-bit sample line.
//
// The block takes one request per cycle while ready is high. A byte request of an
// admitted message is stored in a ring of QUEUE_SAMPLES/16 bytes (rounded up) if a
// slot is free, and gives no response; a tick request gives one response through a
// registered two-entry output buffer, so requests keep flowing while one response
// waits. Once two responses are waiting, ready stays low until the response side
// takes one. The byte being serialized is held in the store's read register, which
// is refetched from the next slot whenever a byte finishes; the write-to-read bypass
// in the store covers a byte written into that slot in the same cycle. The store
// needs no clearing after reset, as only slots holding queued bytes reach the line.
`default_nettype none

module midi_byte_resampled_serializer #(
   parameter int QUEUE_SAMPLES = mbrs_pkg::QUEUE_SAMPLES_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   mbrs_req_if.sink   req_chan,
   mbrs_rsp_if.source rsp_chan
);

   localparam int DEPTH = (QUEUE_SAMPLES + 15) / 16;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SW    = CNT_W + mbrs_pkg::POS_W;
   localparam int CW    = (SW > mbrs_pkg::LEN_SAMPLES_W) ? SW : mbrs_pkg::LEN_SAMPLES_W;
   localparam int POS_W = mbrs_pkg::POS_W;

   logic [AW-1:0]    write_slot_ff, write_slot_in;
   logic [AW-1:0]    read_slot_ff, read_slot_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             admitted_ff, admitted_in;

   logic             accept, tick, enq;
   logic             wr_en;
   logic [7:0]       head_byte;
   logic [CW-1:0]    queued, free_space, need;
   logic             queue_empty;
   mbrs_pkg::rsp_type tick_rsp;

   mbrs_pkg::rsp_type out_q_ff [2];
   logic [1:0]        out_cnt_ff, out_cnt_in;
   logic              pop;
   logic              tick_to_head;

   assign req_chan.ready = (out_cnt_ff != 2'd2);
   assign accept = req_chan.valid && req_chan.ready;
   assign tick   = accept && (req_chan.opcode == mbrs_pkg::OP_TICK);
   assign enq    = accept && (req_chan.opcode == mbrs_pkg::OP_BYTE);

   // Free space is the sample budget less what is still waiting to go out.
   always_comb begin
      queued = CW'({stored_ff, {POS_W{1'b0}}}) - CW'(pos_ff);
      if (queued >= CW'(QUEUE_SAMPLES)) begin
         free_space = '0;
      end else begin
         free_space = CW'(QUEUE_SAMPLES) - queued;
      end
      need = CW'({req_chan.message_length, {POS_W{1'b0}}});
   end

   assign queue_empty = (stored_ff == '0);

   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      stored_in     = stored_ff;
      pos_in        = pos_ff;
      admitted_in   = admitted_ff;
      wr_en         = 1'b0;
      if (enq) begin
         if (req_chan.first_of_message) begin
            admitted_in = (free_space >= need);
         end
         if (admitted_in && (stored_ff < CNT_W'(DEPTH))) begin
            wr_en         = 1'b1;
            write_slot_in = (write_slot_ff == AW'(DEPTH - 1)) ? '0 : write_slot_ff + 1'b1;
            stored_in     = stored_ff + 1'b1;
         end
      end else if (tick && !queue_empty) begin
         if (pos_ff == POS_W'(mbrs_pkg::SAMPLES_PER_BYTE - 1)) begin
            pos_in       = '0;
            read_slot_in = (read_slot_ff == AW'(DEPTH - 1)) ? '0 : read_slot_ff + 1'b1;
            stored_in    = stored_ff - 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         stored_ff     <= '0;
         pos_ff        <= '0;
         admitted_ff   <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         stored_ff     <= stored_in;
         pos_ff        <= pos_in;
         admitted_ff   <= admitted_in;
      end
   end

   mbrs_byte_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_slot_ff),
      .wr_data (req_chan.data_byte),
      .rd_addr (read_slot_in),
      .rd_data (head_byte)
   );

   always_comb begin
      tick_rsp.queue_was_empty = queue_empty;
      tick_rsp.sample_bit      = queue_empty ? 1'b0 : mbrs_pkg::sample_of(head_byte, pos_ff);
   end

   // Two-entry response buffer; entry 0 is the one on offer.
   assign pop          = rsp_chan.valid && rsp_chan.ready;
   assign out_cnt_in   = out_cnt_ff - {1'b0, pop} + {1'b0, tick};
   assign tick_to_head = tick && ((out_cnt_ff - {1'b0, pop}) == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_to_head) begin
         out_q_ff[0] <= tick_rsp;
      end else if (pop) begin
         out_q_ff[0] <= out_q_ff[1];
      end
      if (tick && !tick_to_head) begin
         out_q_ff[1] <= tick_rsp;
      end
   end

   assign rsp_chan.valid           = (out_cnt_ff != 2'd0);
   assign rsp_chan.sample_bit      = out_q_ff[0].sample_bit;
   assign rsp_chan.queue_was_empty = out_q_ff[0].queue_was_empty;

endmodule

`default_nettype wire

// ===== sim/midi_byte_resampled_serializer_tb.sv =====
// Self-checking testbench for the MIDI byte serializer: directed table, then random messages.
`timescale 1ns / 100ps

module midi_byte_resampled_serializer_tb;

   localparam int RING_DEPTH   = (mbrs_pkg::QUEUE_SAMPLES_DEFAULT + 15) / 16;
   localparam int RANDOM_ITEMS = 1700;

   localparam mbrs_pkg::rsp_type IDLE_LINE = '{sample_bit: 1'b0, queue_was_empty: 1'b1};
   localparam mbrs_pkg::rsp_type HIGH_LINE = '{sample_bit: 1'b1, queue_was_empty: 1'b0};

   typedef struct {
      mbrs_pkg::op_type  op;
      logic [7:0]        data;
      logic              first;
      logic [7:0]        len;
      bit                typed;
      mbrs_pkg::rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mbrs_req_if req_chan ();
   mbrs_rsp_if rsp_chan ();

   midi_byte_resampled_serializer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // Directed rows: unusual message framing first, then a message announced at full size and a
   // few short ones; the trailing ticks sample the queued bytes but do not drain them all.
   stim_row_type directed_rows [25] = '{
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd1,   1'b1, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'hA5, 1'b0, 8'd5,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'hFF, 1'b1, 8'd255, 1'b1, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'hFF, 1'b1, 8'd255, 1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h12, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b1, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h00, 1'b1, 8'd128, 1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'hFF, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b1, HIGH_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b1, HIGH_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b1, HIGH_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h80, 1'b1, 8'd128, 1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h55, 1'b1, 8'd1,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'hAA, 1'b1, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h7F, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_BYTE, 8'h01, 1'b0, 8'h80,  1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'hFF, 1'b1, 8'hFF,  1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE},
      '{mbrs_pkg::OP_TICK, 8'h00, 1'b0, 8'd0,   1'b0, IDLE_LINE}
   };

   // Predictor state: the byte ring and the position within the byte on the line.
   logic [7:0] ring [RING_DEPTH];
   int         ring_head;
   int         ring_tail;
   int         ring_count;
   int         bit_phase;
   bit         msg_open;

   mbrs_pkg::rsp_type pending_samples [$];
   mbrs_pkg::rsp_type oldest;
   int         mismatches;
   int         n_items;
   int         n_ticks;
   int         n_empty;
   int         n_stored;
   int         n_dropped_msgs;
   int         n_full_drops;
   bit         calm;

   function automatic logic line_level(input logic [7:0] b, input int pos);
      int k;
      if (pos < 2)
         return 1'b1;
      if (pos > 13)
         return 1'b0;
      // Twelve data samples stretch eight bits by a factor of one and a half.
      k = (2 * (pos - 2) + 1) / 3;
      return ~b[k];
   endfunction

   function automatic mbrs_pkg::rsp_type next_sample();
      mbrs_pkg::rsp_type r;
      n_ticks++;
      if (ring_count == 0) begin
         n_empty++;
         return IDLE_LINE;
      end
      r.sample_bit      = line_level(ring[ring_head], bit_phase);
      r.queue_was_empty = 1'b0;
      if (bit_phase == mbrs_pkg::SAMPLES_PER_BYTE - 1) begin
         bit_phase  = 0;
         ring_head  = (ring_head + 1) % RING_DEPTH;
         ring_count--;
      end else begin
         bit_phase++;
      end
      return r;
   endfunction

   function automatic void take_byte(input logic [7:0] data, input logic first,
                                     input logic [7:0] len);
      int free_space;
      free_space = mbrs_pkg::QUEUE_SAMPLES_DEFAULT
                   - (ring_count * mbrs_pkg::SAMPLES_PER_BYTE - bit_phase);
      if (first) begin
         msg_open = free_space >= int'(len) * mbrs_pkg::SAMPLES_PER_BYTE;
         if (!msg_open)
            n_dropped_msgs++;
      end
      if (msg_open) begin
         if (ring_count < RING_DEPTH) begin
            ring[ring_tail] = data;
            ring_tail       = (ring_tail + 1) % RING_DEPTH;
            ring_count++;
            n_stored++;
         end else begin
            n_full_drops++;
         end
      end
   endfunction

   task automatic send_request(input mbrs_pkg::op_type op, input logic [7:0] data,
                               input logic first, input logic [7:0] len,
                               input bit typed = 1'b0,
                               input mbrs_pkg::rsp_type want = IDLE_LINE);
      mbrs_pkg::rsp_type guess;
      while (!calm && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.opcode           <= op;
      req_chan.data_byte        <= data;
      req_chan.first_of_message <= first;
      req_chan.message_length   <= len;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      n_items++;
      if (op == mbrs_pkg::OP_TICK) begin
         guess = next_sample();
         pending_samples.push_back(typed ? want : guess);
      end else begin
         take_byte(data, first, len);
      end
   endtask

   task automatic send_tick();
      send_request(mbrs_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   8'($urandom_range(255)));
   endtask

   always @(posedge clock)
      rsp_chan.ready <= calm || ($urandom_range(99) >= 30);

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_samples.size() == 0) begin
            $error("response with no request waiting: sample_bit %0b queue_was_empty %0b",
                   rsp_chan.sample_bit, rsp_chan.queue_was_empty);
            mismatches++;
         end else begin
            oldest = pending_samples.pop_front();
            if (rsp_chan.sample_bit !== oldest.sample_bit) begin
               $error("sample_bit: expected %0b, got %0b", oldest.sample_bit,
                      rsp_chan.sample_bit);
               mismatches++;
            end
            if (rsp_chan.queue_was_empty !== oldest.queue_was_empty) begin
               $error("queue_was_empty: expected %0b, got %0b", oldest.queue_was_empty,
                      rsp_chan.queue_was_empty);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int         base;
      int         pick;
      int         nbytes;
      bit         filling;
      logic [7:0] len;

      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.opcode           = mbrs_pkg::OP_TICK;
      req_chan.data_byte        = 8'h00;
      req_chan.first_of_message = 1'b0;
      req_chan.message_length   = 8'h00;
      rsp_chan.ready            = 1'b0;
      calm                      = 1'b0;
      filling                   = 1'b1;
      ring_head                 = 0;
      ring_tail                 = 0;
      ring_count                = 0;
      bit_phase                 = 0;
      msg_open                  = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].first,
                      directed_rows[i].len, directed_rows[i].typed, directed_rows[i].want);

      base = n_items;
      while (n_items - base < RANDOM_ITEMS) begin
         // A stretch in the middle runs with both sides always ready.
         calm = (n_items - base >= 600) && (n_items - base < 900);
         if (ring_count >= RING_DEPTH - 2)
            filling = 1'b0;
         else if (ring_count == 0 && $urandom_range(3) == 0)
            filling = 1'b1;

         pick = $urandom_range(99);
         if (pick < 80) begin
            pick = $urandom_range(99);
            if (pick < 60)
               len = 8'($urandom_range(1, 3));
            else if (pick < 85)
               len = 8'($urandom_range(4, 32));
            else if (pick < 93)
               len = 8'($urandom_range(33, 128));
            else if (pick < 96)
               len = 8'd0;
            else
               len = 8'($urandom_range(129, 255));
            nbytes = (len == 0) ? int'($urandom_range(1, 40)) : int'(len);
            // Now and then the message runs short of, or past, its announced length.
            if ($urandom_range(9) == 0)
               nbytes = $urandom_range(1, nbytes + 8);
            for (int k = 0; k < nbytes; k++) begin
               send_request(mbrs_pkg::OP_BYTE, 8'($urandom_range(255)), k == 0,
                            (k == 0) ? len : 8'($urandom_range(255)));
               if (!filling && $urandom_range(4) == 0)
                  repeat ($urandom_range(1, 3)) send_tick();
            end
            repeat (filling ? $urandom_range(0, 3) : $urandom_range(0, 64)) send_tick();
         end else if (pick < 90) begin
            send_request(mbrs_pkg::op_type'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(mbrs_pkg::OP_BYTE, 8'($urandom_range(255)), 1'b0,
                            8'($urandom_range(255)));
         end
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("summary: %0d requests, %0d ticks (%0d on an empty line), %0d bytes queued",
               n_items, n_ticks, n_empty, n_stored);
      $display("summary: %0d messages refused for space, %0d bytes lost to a full store",
               n_dropped_msgs, n_full_drops);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
